/* rtl/oaa_pkg.sv */
package oaa_pkg;

	// Frame and ring geometry. The ring is a power of two so positions wrap by truncation.
	localparam int WINDOW_SIZE = 256;
	localparam int RING_SHIFT  = 3;
	localparam int RING_SIZE   = WINDOW_SIZE << RING_SHIFT;
	localparam int RING_AW     = $clog2(RING_SIZE);
	localparam int OFS_W       = $clog2(WINDOW_SIZE);

	// Field widths.
	localparam int SAMPLE_W    = 24;
	localparam int ACC_W       = 27;
	localparam int SUM_W       = ACC_W + 1;
	localparam int READY_W     = 11;
	localparam int HOP_W       = 9;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - ACC_W - READY_W;

	// Configuration port.
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int REG_IDX_W   = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_HOP_SIZE = REG_IDX_W'(0);
	localparam logic [HOP_W-1:0]     HOP_RESET    = HOP_W'(64);

	// Saturation limits of the accumulator.
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic {
		MODE_ADD  = 1'b0,
		MODE_READ = 1'b1
	} mode_t;

endpackage

/* rtl/overlap_add_accumulator.sv */
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tuser: mode; s_tdata: frame_sample
// m_*       out  m_tvalid / m_tready    m_tuser: out_valid; m_tdata: out_sample, samples_ready
// APB       in   psel, penable, pready  register 0 at byte address 0: hop_size
//
// One word is accepted per cycle while no clearing pass runs and the output is not stalled;
// its result passes through the second stage and then the output register. The rate is set by
// the single read-modify-write port pair of the ring memory, with forwarding of the write-back
// to a read issued in the same cycle. After reset a clearing pass writes zero to all RING_SIZE
// (2048) ring entries, one per cycle; s_tready stays low until it ends, while APB writes are taken.
// A stalled output holds one result in the output register and one in the second stage.
module overlap_add_accumulator (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [oaa_pkg::IN_TDATA_W-1:0]  s_tdata,   // [23:0] frame_sample
	input  logic [0:0]                      s_tuser,   // [0] mode
	// Output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [oaa_pkg::OUT_TDATA_W-1:0] m_tdata,   // [26:0] out_sample, [37:27] samples_ready, [39:38] zero
	output logic [0:0]                      m_tuser,   // [0] out_valid
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [oaa_pkg::PADDR_W-1:0]     paddr,
	input  logic [oaa_pkg::PDATA_W-1:0]     pwdata,
	output logic [oaa_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);
	import oaa_pkg::*;

	// Configuration register.
	logic [HOP_W-1:0]     hop_q;
	logic [REG_IDX_W-1:0] reg_idx;

	// Ring control state and clearing pass.
	logic [RING_AW-1:0]   write_pos_q;
	logic [RING_AW-1:0]   read_pos_q;
	logic [OFS_W-1:0]     frame_ofs_q;
	logic                 clr_busy_q;
	logic [RING_AW-1:0]   clr_addr_q;

	// Accumulator memory.
	logic signed [ACC_W-1:0] acc_mem [RING_SIZE];
	logic signed [ACC_W-1:0] mem_rdata_s1;
	logic                    mem_we;
	logic [RING_AW-1:0]      mem_waddr;
	logic signed [ACC_W-1:0] mem_wdata;

	// First stage: handshake, position update and read address.
	logic                 accept;
	logic                 out_free;
	mode_t                in_mode;
	logic [RING_AW-1:0]   rd_addr;
	logic                 rd_hit;
	logic [RING_AW-1:0]   write_pos_nxt;
	logic [RING_AW-1:0]   read_pos_nxt;
	logic [OFS_W-1:0]     frame_ofs_nxt;

	// Second stage: read data, add or fetch, write back.
	logic                    valid_s1;
	mode_t                   mode_s1;
	logic                    hit_s1;
	logic [RING_AW-1:0]      addr_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [READY_W-1:0]      ready_s1;
	logic                    fwd_hit_s1;
	logic signed [ACC_W-1:0] fwd_data_s1;
	logic signed [ACC_W-1:0] cur_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic signed [ACC_W-1:0] sat_s1;
	logic                    s1_we;
	logic signed [ACC_W-1:0] s1_wdata;
	logic                    s1_adv;

	// Output register.
	logic                    m_valid_q;
	logic signed [ACC_W-1:0] out_sample_q;
	logic                    out_valid_q;
	logic [READY_W-1:0]      samples_ready_q;

	// ---------------------------------------------------------------- configuration
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q <= HOP_RESET;
		end else if (psel && penable && pwrite && (reg_idx == REG_HOP_SIZE)) begin
			hop_q <= pwdata[HOP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_HOP_SIZE) begin
			prdata = PDATA_W'(hop_q);
		end
	end

	// ---------------------------------------------------------------- first stage
	// A word may enter whenever no clearing pass runs and the second stage is empty or moves on in this cycle.
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = !clr_busy_q && (!valid_s1 || out_free);
	assign accept   = s_tvalid && s_tready;
	assign in_mode  = mode_t'(s_tuser[0]);
	assign s1_adv   = valid_s1 && out_free;

	// Positions are updated when the word enters, since they never depend on ring data.
	always_comb begin
		write_pos_nxt = write_pos_q;
		read_pos_nxt  = read_pos_q;
		frame_ofs_nxt = frame_ofs_q;
		rd_hit        = 1'b0;
		rd_addr       = write_pos_q + RING_AW'(frame_ofs_q);
		case (in_mode)
			MODE_ADD: begin
				if (frame_ofs_q == OFS_W'(WINDOW_SIZE - 1)) begin
					frame_ofs_nxt = '0;
					write_pos_nxt = write_pos_q + RING_AW'(hop_q);
				end else begin
					frame_ofs_nxt = frame_ofs_q + OFS_W'(1);
				end
			end
			MODE_READ: begin
				rd_addr = read_pos_q;
				rd_hit  = (write_pos_q != read_pos_q);
				if (rd_hit) begin
					read_pos_nxt = read_pos_q + RING_AW'(1);
				end
			end
			default: begin
				rd_addr = read_pos_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			read_pos_q  <= '0;
			frame_ofs_q <= '0;
		end else if (accept) begin
			write_pos_q <= write_pos_nxt;
			read_pos_q  <= read_pos_nxt;
			frame_ofs_q <= frame_ofs_nxt;
		end
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + RING_AW'(1);
			if (clr_addr_q == RING_AW'(RING_SIZE - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- ring memory
	assign mem_we    = clr_busy_q || s1_we;
	assign mem_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clr_busy_q ? '0 : s1_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			acc_mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			mem_rdata_s1 <= acc_mem[rd_addr];
		end
	end

	// ---------------------------------------------------------------- second stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// The memory read of an entering word misses a write-back to the same entry at the
	// same edge, so that write-back is captured beside it.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= in_mode;
			hit_s1      <= rd_hit;
			addr_s1     <= rd_addr;
			sample_s1   <= s_tdata[SAMPLE_W-1:0];
			ready_s1    <= READY_W'(write_pos_nxt - read_pos_nxt);
			fwd_hit_s1  <= s1_we && (addr_s1 == rd_addr);
			fwd_data_s1 <= s1_wdata;
		end
	end

	assign cur_s1 = fwd_hit_s1 ? fwd_data_s1 : mem_rdata_s1;
	assign sum_s1 = SUM_W'(cur_s1) + SUM_W'(sample_s1);

	always_comb begin
		sat_s1 = sum_s1[ACC_W-1:0];
		if (sum_s1[SUM_W-1] != sum_s1[SUM_W-2]) begin
			sat_s1 = sum_s1[SUM_W-1] ? ACC_MIN : ACC_MAX;
		end
	end

	// A sum is written back for an add; a read that found a sample clears its entry.
	assign s1_we    = s1_adv && ((mode_s1 == MODE_ADD) || hit_s1);
	assign s1_wdata = (mode_s1 == MODE_ADD) ? sat_s1 : '0;

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_sample_q    <= ((mode_s1 == MODE_READ) && hit_s1) ? cur_s1 : '0;
			out_valid_q     <= (mode_s1 == MODE_READ) && hit_s1;
			samples_ready_q <= ready_s1;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {{OUT_PAD_W{1'b0}}, samples_ready_q, out_sample_q};
	assign m_tuser[0] = out_valid_q;

`ifndef SYNTHESIS
	// No word may sit in the second stage while the clearing pass owns the write port.
	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !valid_s1)
		else $error("word in flight during clearing pass");

	// A stalled second stage keeps its word and target entry.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(addr_s1))
		else $error("second stage lost a stalled word");

	// A word leaving the second stage shows up on the output.
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> m_valid_q)
		else $error("result dropped between second stage and output");

	// A read with nothing ready leaves the read position alone.
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_mode == MODE_READ) && (write_pos_q == read_pos_q)
			|=> $stable(read_pos_q))
		else $error("read position moved on an empty ring");
`endif

endmodule
